FILE: sv/rbtt_pkg.sv
package rbtt_pkg;

    // Field widths
    localparam int REM_W   = 24;   // remaining time in scan ticks
    localparam int CNT_W   = 3;    // retry counter
    localparam int BASE_W  = 16;   // base timeout register
    localparam int SLOT_W  = 4;    // slot field on the ports
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXR = 1'b1;

    // Configuration reset values
    localparam logic [BASE_W-1:0] BASE_RST = 16'd20;
    localparam logic [CNT_W-1:0]  MAXR_RST = 3'd3;

    // Event codes
    localparam logic EV_RETX   = 1'b0;
    localparam logic EV_GIVEUP = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_RESTART = 2'd2,
        OP_STOP    = 2'd3
    } t_op;

    // One timer table entry
    typedef struct packed {
        logic [REM_W-1:0] remaining;
        logic [CNT_W-1:0] retries;
    } t_entry;

    // Outcome of updating one entry on a tick
    typedef struct packed {
        logic             we;       // write entry back
        t_entry           entry;    // value to write back
        logic             expire;   // timer reached zero
        logic             giveup;   // slot is freed
        logic [CNT_W-1:0] cnt;      // retry count reported
    } t_upd;

endpackage

FILE: sv/retransmit_backoff_timer_table.sv
// Retransmission timer table with exponential backoff, SLOTS connection slots.
// Command channel: start/busy. A word (operation, slot) is taken when start is
// high and busy is low. Start, restart and stop take effect at that edge and
// never raise busy; slots at or above SLOTS are ignored. A tick keeps busy
// high through scan, drain and flush: the scan reads one slot per cycle from
// the timer memory (one read, one write port), updates it and writes it back
// in the next cycle, then drains and flushes the last event.
// Events leave on o_strobe for exactly one cycle each; o_last marks the final
// event of a tick. Each event is held until the next expiry (or the end of the
// scan) is seen so that o_last is known: it leaves in the cycle after the
// write-back of the next expiring slot, and the last event of a tick leaves in
// the cycle in which busy drops. The receiver cannot stall.
// Configuration: i_cfg_valid/o_cfg_ready, index 0 base_timeout, 1 max_retries;
// write only while idle. o_cfg_ready is always high.
// Reset (synchronous, active low) clears all active bits, loads base_timeout
// 20 and max_retries 3. Memory contents of a slot are only used after a start
// has loaded them, so the memory needs no clearing pass.
module retransmit_backoff_timer_table #(
    parameter int SLOTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_operation,
    input  logic [rbtt_pkg::SLOT_W-1:0]        i_slot,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbtt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbtt_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic [rbtt_pkg::SLOT_W-1:0]        o_slot_res,
    output logic                               o_event_res,
    output logic [rbtt_pkg::CNT_W-1:0]         o_retry_count,
    output logic                               o_last
);
    import rbtt_pkg::*;

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [BASE_W-1:0] r_base_timeout;
    logic [CNT_W-1:0]  r_max_retries;
    logic [SLOTS-1:0]  r_active;
    logic [IDXW-1:0]   r_rd_idx;
    logic              r_wb_valid;
    logic [IDXW-1:0]   r_wb_idx;

    // Held event, emitted once the next one (or the end of scan) is seen
    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              r_pend_ev;
    logic [CNT_W-1:0]  r_pend_cnt;

    logic              r_out_strobe;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_ev;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              accept;
    logic              cmd_ok;
    logic [IDXW-1:0]   cmd_idx;
    t_op               op;
    t_entry            rd_entry;
    t_entry            load_entry;
    t_upd              upd;
    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    t_entry            mem_wdata;
    logic              wb_act;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign op          = t_op'(i_operation);
    assign cmd_idx     = IDXW'(i_slot);
    assign cmd_ok      = (32'(i_slot) < SLOTS);
    assign o_cfg_ready = 1'b1;
    assign wb_act      = r_wb_valid && r_active[r_wb_idx];

    assign load_entry.remaining = REM_W'(r_base_timeout);
    assign load_entry.retries   = '0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_timeout <= BASE_RST;
            r_max_retries  <= MAXR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE: r_base_timeout <= i_cfg_data;
                CFG_MAXR: r_max_retries  <= i_cfg_data[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    // Scan sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && op == OP_TICK) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_rd_idx == IDXW'(SLOTS - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_idx   <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wb_valid <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_rd_idx <= r_rd_idx + IDXW'(1);
            end else begin
                r_rd_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_rd_idx;
    end

    // Memory write port: commands while idle, write-back during scan
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wb_idx;
        mem_wdata = upd.entry;
        if (accept && cmd_ok && (op == OP_START || op == OP_RESTART)) begin
            mem_we    = 1'b1;
            mem_waddr = cmd_idx;
            mem_wdata = load_entry;
        end else if (r_wb_valid && upd.we) begin
            mem_we = 1'b1;
        end
    end

    rbtt_mem #(
        .DEPTH (SLOTS),
        .AW    (IDXW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_entry)
    );

    rbtt_update u_update (
        .i_entry  (rd_entry),
        .i_active (wb_act),
        .i_base   (r_base_timeout),
        .i_max    (r_max_retries),
        .o_upd    (upd)
    );

    // Active bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (accept && cmd_ok && op == OP_START) begin
            r_active[cmd_idx] <= 1'b1;
        end else if (accept && cmd_ok && op == OP_STOP) begin
            r_active[cmd_idx] <= 1'b0;
        end else if (wb_act && upd.giveup) begin
            r_active[r_wb_idx] <= 1'b0;
        end
    end

    // Event holding stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= 1'b0;
            if (wb_act && upd.expire) begin
                r_out_strobe <= r_pend_valid;
                r_pend_valid <= 1'b1;
            end else if (r_state == ST_FLUSH) begin
                r_out_strobe <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_act && upd.expire) begin
            r_pend_slot <= SLOT_W'(r_wb_idx);
            r_pend_ev   <= upd.giveup ? EV_GIVEUP : EV_RETX;
            r_pend_cnt  <= upd.cnt;
            r_out_slot  <= r_pend_slot;
            r_out_ev    <= r_pend_ev;
            r_out_cnt   <= r_pend_cnt;
            r_out_last  <= 1'b0;
        end else if (r_state == ST_FLUSH) begin
            r_out_slot  <= r_pend_slot;
            r_out_ev    <= r_pend_ev;
            r_out_cnt   <= r_pend_cnt;
            r_out_last  <= 1'b1;
        end
    end

    assign o_strobe      = r_out_strobe;
    assign o_slot_res    = r_out_slot;
    assign o_event_res   = r_out_ev;
    assign o_retry_count = r_out_cnt;
    assign o_last        = r_out_last;

    // Events only come out of a tick scan
    a_strobe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != ST_IDLE))
        else $error("event strobe outside a tick scan");

    // Write-back stage only follows scan reads
    a_wb_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("write-back outside scan");

    // Final event leaves nothing held and ends the tick
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (!r_pend_valid && r_state == ST_IDLE))
        else $error("event still held after last");

    // No event stays held between ticks
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held event while idle");

endmodule

FILE: sv/rbtt_mem.sv
module rbtt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  rbtt_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output rbtt_pkg::t_entry  o_rdata
);
    import rbtt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rbtt_update.sv
module rbtt_update (
    input  rbtt_pkg::t_entry                 i_entry,
    input  logic                             i_active,
    input  logic [rbtt_pkg::BASE_W-1:0]      i_base,
    input  logic [rbtt_pkg::CNT_W-1:0]       i_max,
    output rbtt_pkg::t_upd                   o_upd
);
    import rbtt_pkg::*;

    logic [REM_W-1:0] dec;
    logic [CNT_W-1:0] cnt_inc;
    logic [3:0]       shift;

    // Saturating decrement, then retransmit or give up at zero
    always_comb begin
        dec     = (i_entry.remaining == '0) ? '0 : i_entry.remaining - REM_W'(1);
        cnt_inc = i_entry.retries + CNT_W'(1);
        shift   = 4'(cnt_inc) + 4'd1;
        o_upd   = '0;
        if (i_active) begin
            if (dec != '0) begin
                o_upd.we              = 1'b1;
                o_upd.entry.remaining = dec;
                o_upd.entry.retries   = i_entry.retries;
            end else if (i_entry.retries >= i_max) begin
                o_upd.expire = 1'b1;
                o_upd.giveup = 1'b1;
                o_upd.cnt    = i_entry.retries;
            end else begin
                o_upd.we              = 1'b1;
                o_upd.entry.remaining = REM_W'(i_base) << shift;
                o_upd.entry.retries   = cnt_inc;
                o_upd.expire          = 1'b1;
                o_upd.cnt             = cnt_inc;
            end
        end
    end

endmodule
